FILE: design/dpt_pkg.sv
`timescale 1ns / 1ps

package dpt_pkg;

   localparam int OP_W         = 2;
   localparam int ADDR_W       = 14;
   localparam int STATUS_W     = 2;
   localparam int RAM_ADDR_W   = 12;
   localparam int LOAD_PAGE_W  = 6;
   localparam int LOAD_FRAME_W = 8;
   localparam int FAULT_W      = 32;

   typedef enum logic [OP_W-1:0] {
      OP_FETCH   = 2'd0,
      OP_PRELOAD = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FAULT   = 2'd1,
      ST_NO_PAGE = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FRAME,
      S_DECIDE,
      S_WORD,
      S_ADDR
   } state_type;

   typedef struct packed {
      logic load;
      logic frame_en;
      logic off_en;
      logic word_en;
   } addr_ctl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: design/dpt_if.sv
`timescale 1ns / 1ps

interface dpt_req_if import dpt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ADDR_W-1:0]   disk_address;

   modport source (output valid, output operation, output disk_address, input ready);
   modport sink (input valid, input operation, input disk_address, output ready);
endinterface

interface dpt_rsp_if import dpt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [RAM_ADDR_W-1:0]   ram_address;
   logic                    load_request;
   logic [LOAD_PAGE_W-1:0]  load_page;
   logic [LOAD_FRAME_W-1:0] load_frame;
   logic [FAULT_W-1:0]      fault_total;

   modport source (output valid, output status, output ram_address, output load_request,
                   output load_page, output load_frame, output fault_total, input ready);
   modport sink (input valid, input status, input ram_address, input load_request,
                 input load_page, input load_frame, input fault_total, output ready);
endinterface

FILE: design/dpt_ram.sv
`timescale 1ns / 1ps

module dpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/dpt_addr.sv
`timescale 1ns / 1ps

module dpt_addr import dpt_pkg::*; #(
   parameter int RAM_PAGES   = 64,
   parameter int DISK_FRAMES = 256,
   parameter int PAGE_BYTES  = 64,
   parameter int WORD_BYTES  = 4,
   localparam int PAGE_W     = $clog2(RAM_PAGES),
   localparam int FRAME_W    = $clog2(DISK_FRAMES)
) (
   input  logic                  clock,
   input  addr_ctl_type          ctl,
   input  logic [ADDR_W-1:0]     disk_address,
   input  logic [PAGE_W-1:0]     page,
   output logic [FRAME_W-1:0]    frame_idx,
   output logic [FRAME_W-1:0]    frame,
   output logic                  in_range,
   output logic [RAM_ADDR_W-1:0] ram_address
);

   // frame = address / PAGE_BYTES by reciprocal multiply
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int K1    = ADDR_W + OFF_W;
   localparam int M1    = ((1 << K1) + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int M1_W  = ADDR_W + 1;
   localparam int P1_W  = ADDR_W + M1_W;
   localparam int QUO_W = P1_W - K1;
   localparam int CMP_W = max_int(QUO_W, FRAME_W + 1);

   // word index = byte offset / WORD_BYTES
   localparam int LW    = $clog2(WORD_BYTES);
   localparam int K2    = OFF_W + LW;
   localparam int M2    = ((1 << K2) + WORD_BYTES - 1) / WORD_BYTES;
   localparam int M2_W  = OFF_W + 1;
   localparam int P2_W  = OFF_W + M2_W;
   localparam int WI_W  = P2_W - K2;

   localparam int SUM_W = PAGE_W + OFF_W + 1;
   localparam int EXT_W = max_int(SUM_W, RAM_ADDR_W);

   logic [ADDR_W-1:0]  addr_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic               in_range_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [WI_W-1:0]    wi_ff;

   logic [P1_W-1:0]    prod1;
   logic [QUO_W-1:0]   quo;
   logic [CMP_W-1:0]   quo_ext;
   logic               in_range_c;
   logic [ADDR_W-1:0]  frame_base;
   logic [ADDR_W-1:0]  byte_off;
   logic [P2_W-1:0]    prod2;
   logic [WI_W-1:0]    wi;
   logic [SUM_W-1:0]   sum;
   logic [EXT_W-1:0]   sum_ext;

   assign prod1      = P1_W'(addr_ff) * P1_W'(M1);
   assign quo        = prod1[P1_W-1:K1];
   assign quo_ext    = CMP_W'(quo);
   assign in_range_c = quo_ext < CMP_W'(DISK_FRAMES);
   assign frame_idx  = quo_ext[FRAME_W-1:0];

   assign frame_base = ADDR_W'(quo_ff) * ADDR_W'(PAGE_BYTES);
   assign byte_off   = addr_ff - frame_base;

   assign prod2      = P2_W'(off_ff) * P2_W'(M2);
   assign wi         = prod2[P2_W-1:K2];

   assign sum        = SUM_W'(page) * SUM_W'(PAGE_BYTES) + SUM_W'(wi_ff) * SUM_W'(WORD_BYTES);
   assign sum_ext    = EXT_W'(sum);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         addr_ff <= disk_address;
      end
      if (ctl.frame_en) begin
         quo_ff      <= quo;
         frame_ff    <= frame_idx;
         in_range_ff <= in_range_c;
      end
      if (ctl.off_en) begin
         off_ff <= byte_off[OFF_W-1:0];
      end
      if (ctl.word_en) begin
         wi_ff <= wi;
      end
   end

   assign frame       = frame_ff;
   assign in_range    = in_range_ff;
   assign ram_address = sum_ext[RAM_ADDR_W-1:0];

endmodule

FILE: design/demand_paging_translator.sv
`timescale 1ns / 1ps

// channel  dir  payload
// req_ch   in   operation, disk_address
// rsp_ch   out  status, ram_address, load_request, load_page, load_frame, fault_total
//
// a transaction runs from acceptance to the result register in these steps: frame split
// (reciprocal multiply) with the map and free-queue reads, decide and write back,
// byte offset to word index, then address build and result load; the next one is taken
// only back in the idle step, so none is accepted before the last is through
// after reset a clearing pass over the larger of the two memories fills both of them;
// req_ch.ready stays low until it ends
// a new transaction is taken while a result waits; the block holds in its last step
// until the result register is free

module demand_paging_translator import dpt_pkg::*; #(
   parameter int RAM_PAGES   = 64,
   parameter int DISK_FRAMES = 256,
   parameter int PAGE_BYTES  = 64,
   parameter int WORD_BYTES  = 4
) (
   input logic       clock,
   input logic       reset,
   dpt_req_if.sink   req_ch,
   dpt_rsp_if.source rsp_ch
);

   localparam int PAGE_W   = $clog2(RAM_PAGES);
   localparam int FRAME_W  = $clog2(DISK_FRAMES);
   localparam int CNT_W    = $clog2(RAM_PAGES + 1);
   localparam int MAP_W    = PAGE_W + 1;
   localparam int INIT_N   = max_int(DISK_FRAMES, RAM_PAGES);
   localparam int INIT_W   = $clog2(INIT_N);
   localparam int LP_EXT_W = max_int(PAGE_W, LOAD_PAGE_W);
   localparam int LF_EXT_W = max_int(FRAME_W, LOAD_FRAME_W);

   localparam logic [CNT_W-1:0]  QUEUE_FULL = CNT_W'(RAM_PAGES);
   localparam logic [PAGE_W-1:0] PAGE_LAST  = PAGE_W'(RAM_PAGES - 1);
   localparam logic [INIT_W-1:0] INIT_LAST  = INIT_W'(INIT_N - 1);

   state_type state_ff, state_in;

   logic [INIT_W-1:0]       init_cnt_ff, init_cnt_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [PAGE_W-1:0]       head_ff, head_in;
   logic [PAGE_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [FAULT_W-1:0]      fault_ff, fault_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   status_type              status_ff, status_in;
   logic                    use_ram_ff, use_ram_in;
   logic                    load_req_ff, load_req_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [RAM_ADDR_W-1:0]   rsp_ram_ff, rsp_ram_in;
   logic                    rsp_load_req_ff, rsp_load_req_in;
   logic [LOAD_PAGE_W-1:0]  rsp_load_page_ff, rsp_load_page_in;
   logic [LOAD_FRAME_W-1:0] rsp_load_frame_ff, rsp_load_frame_in;
   logic [FAULT_W-1:0]      rsp_fault_ff, rsp_fault_in;

   logic                    req_ready;
   logic                    out_free;
   logic                    pop;
   logic                    push;
   addr_ctl_type            ctl;

   logic                    map_we;
   logic [FRAME_W-1:0]      map_waddr;
   logic [MAP_W-1:0]        map_wdata;
   logic [FRAME_W-1:0]      map_raddr;
   logic [MAP_W-1:0]        map_rdata;
   logic                    map_hit;
   logic [PAGE_W-1:0]       map_page;

   logic                    q_we;
   logic [PAGE_W-1:0]       q_waddr;
   logic [PAGE_W-1:0]       q_wdata;
   logic [PAGE_W-1:0]       q_raddr;
   logic [PAGE_W-1:0]       q_rdata;

   logic [FRAME_W-1:0]      frame_idx;
   logic [FRAME_W-1:0]      frame_q;
   logic                    in_range;
   logic [RAM_ADDR_W-1:0]   ram_sum;
   logic [LP_EXT_W-1:0]     lp_ext;
   logic [LF_EXT_W-1:0]     lf_ext;

   dpt_addr #(
      .RAM_PAGES   (RAM_PAGES),
      .DISK_FRAMES (DISK_FRAMES),
      .PAGE_BYTES  (PAGE_BYTES),
      .WORD_BYTES  (WORD_BYTES)
   ) u_addr (
      .clock        (clock),
      .ctl          (ctl),
      .disk_address (req_ch.disk_address),
      .page         (page_ff),
      .frame_idx    (frame_idx),
      .frame        (frame_q),
      .in_range     (in_range),
      .ram_address  (ram_sum)
   );

   // frame map: valid bit over page index
   dpt_ram #(
      .WIDTH (MAP_W),
      .DEPTH (DISK_FRAMES)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   // free page fifo
   dpt_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (RAM_PAGES)
   ) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   assign map_hit  = map_rdata[PAGE_W];
   assign map_page = map_rdata[PAGE_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign lp_ext   = LP_EXT_W'(page_ff);
   assign lf_ext   = LF_EXT_W'(frame_q);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (init_cnt_ff == INIT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_FRAME;
            end
         end
         S_FRAME:  state_in = S_DECIDE;
         S_DECIDE: state_in = S_WORD;
         S_WORD:   state_in = S_ADDR;
         S_ADDR: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_INIT;
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      ctl               = '0;
      pop               = 1'b0;
      push              = 1'b0;
      map_we            = 1'b0;
      map_waddr         = frame_q;
      map_wdata         = '0;
      map_raddr         = frame_idx;
      q_we              = 1'b0;
      q_waddr           = tail_ff;
      q_wdata           = map_page;
      q_raddr           = head_ff;
      init_cnt_in       = init_cnt_ff;
      op_in             = op_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      fault_in          = fault_ff;
      page_in           = page_ff;
      status_in         = status_ff;
      use_ram_in        = use_ram_ff;
      load_req_in       = load_req_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_ram_in        = rsp_ram_ff;
      rsp_load_req_in   = rsp_load_req_ff;
      rsp_load_page_in  = rsp_load_page_ff;
      rsp_load_frame_in = rsp_load_frame_ff;
      rsp_fault_in      = rsp_fault_ff;

      unique case (state_ff)
         S_INIT: begin
            init_cnt_in = init_cnt_ff + 1'b1;
            map_we      = int'(init_cnt_ff) < DISK_FRAMES;
            map_waddr   = init_cnt_ff[FRAME_W-1:0];
            map_wdata   = '0;
            q_we        = int'(init_cnt_ff) < RAM_PAGES;
            q_waddr     = init_cnt_ff[PAGE_W-1:0];
            q_wdata     = init_cnt_ff[PAGE_W-1:0];
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               ctl.load = 1'b1;
               op_in    = req_ch.operation;
            end
         end
         S_FRAME: begin
            ctl.frame_en = 1'b1;
         end
         S_DECIDE: begin
            ctl.off_en  = 1'b1;
            status_in   = ST_IGNORED;
            use_ram_in  = 1'b0;
            load_req_in = 1'b0;
            page_in     = map_page;
            if (in_range) begin
               unique case (op_ff)
                  OP_FETCH: begin
                     if (map_hit) begin
                        status_in  = ST_DONE;
                        use_ram_in = 1'b1;
                     end else if (count_ff == '0) begin
                        status_in = ST_NO_PAGE;
                     end else begin
                        pop         = 1'b1;
                        status_in   = ST_FAULT;
                        use_ram_in  = 1'b1;
                        load_req_in = 1'b1;
                        page_in     = q_rdata;
                        fault_in    = fault_ff + 1'b1;
                     end
                  end
                  OP_PRELOAD: begin
                     if (map_hit) begin
                        status_in = ST_IGNORED;
                     end else if (count_ff == '0) begin
                        status_in = ST_NO_PAGE;
                     end else begin
                        pop         = 1'b1;
                        status_in   = ST_DONE;
                        load_req_in = 1'b1;
                        page_in     = q_rdata;
                     end
                  end
                  OP_RELEASE: begin
                     if (map_hit) begin
                        map_we    = 1'b1;
                        map_wdata = {1'b0, map_page};
                        status_in = ST_DONE;
                        push      = count_ff != QUEUE_FULL;
                     end
                  end
                  default: begin
                     status_in = ST_IGNORED;
                  end
               endcase
            end
            if (pop) begin
               map_we    = 1'b1;
               map_wdata = {1'b1, q_rdata};
               head_in   = (head_ff == PAGE_LAST) ? '0 : head_ff + 1'b1;
               count_in  = count_ff - 1'b1;
            end
            if (push) begin
               q_we     = 1'b1;
               q_wdata  = map_page;
               tail_in  = (tail_ff == PAGE_LAST) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         S_WORD: begin
            ctl.word_en = 1'b1;
         end
         S_ADDR: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_ram_in        = use_ram_ff ? ram_sum : '0;
               rsp_load_req_in   = load_req_ff;
               rsp_load_page_in  = load_req_ff ? lp_ext[LOAD_PAGE_W-1:0] : '0;
               rsp_load_frame_in = load_req_ff ? lf_ext[LOAD_FRAME_W-1:0] : '0;
               rsp_fault_in      = fault_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= QUEUE_FULL;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      page_ff           <= page_in;
      status_ff         <= status_in;
      use_ram_ff        <= use_ram_in;
      load_req_ff       <= load_req_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_ram_ff        <= rsp_ram_in;
      rsp_load_req_ff   <= rsp_load_req_in;
      rsp_load_page_ff  <= rsp_load_page_in;
      rsp_load_frame_ff <= rsp_load_frame_in;
      rsp_fault_ff      <= rsp_fault_in;
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.ram_address  = rsp_ram_ff;
   assign rsp_ch.load_request = rsp_load_req_ff;
   assign rsp_ch.load_page    = rsp_load_page_ff;
   assign rsp_ch.load_frame   = rsp_load_frame_ff;
   assign rsp_ch.fault_total  = rsp_fault_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("page taken from an empty free queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != QUEUE_FULL)
      else $error("page queued into a full free queue");

   a_map_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && map_we) |-> in_range)
      else $error("map written for a frame outside the disk");

   a_rsp_from_addr: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == S_ADDR))
      else $error("result loaded outside the address step");

   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fault_ff != $past(fault_ff))
         |-> $past(state_ff == S_DECIDE && status_in == ST_FAULT))
      else $error("fault counter moved without a serviced fault");

endmodule
